FILE: rtl/indexed_shift_list_unit_macros.svh
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef INDEXED_SHIFT_LIST_UNIT_MACROS_SVH
`define INDEXED_SHIFT_LIST_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define ISL_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("isl: same-cycle check failed");

`define ISL_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("isl: next-cycle check failed");

`else

`define ISL_ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define ISL_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

FILE: rtl/isl_pkg.sv
package isl_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W  = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int KIND_W = 3;
  localparam int IDX_W  = 5;
  localparam int ITEM_W = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;

  localparam int CMP_W = (IDX_W > LEN_W) ? IDX_W : LEN_W;

  localparam int IN_TDATA_W  = ((IDX_W + ITEM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET    = 3'd0,
    KIND_SET    = 3'd1,
    KIND_APPEND = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_REMOVE = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [IDX_W-1:0]     pos;
    logic [WORD_BITS-1:0] word;
  } req_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic              ok;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

FILE: rtl/isl_ram.sv
module isl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/isl_ctrl.sv
`include "indexed_shift_list_unit_macros.svh"

module isl_ctrl
  import isl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output ram_req_t             ram,
  input  logic [WORD_BITS-1:0] ram_rdata,
  output res_t                 res,
  input  logic                 res_ready
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_RDUSE    = 6'b000010,
    ST_SHIFT_RD = 6'b000100,
    ST_SHIFT_WR = 6'b001000,
    ST_PUT      = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [LEN_W-1:0]     length, length_next;
  logic [LEN_W-1:0]     cur, cur_next;
  logic [WORD_BITS-1:0] res_data, res_data_next;
  logic                 res_ok, res_ok_next;
  kind_t                req_kind;
  logic [IDX_W-1:0]     req_pos;
  logic [WORD_BITS-1:0] req_item;

  logic [CMP_W-1:0] len_e, in_pos_e, req_pos_e;
  logic             full;
  logic             accept;

  assign len_e     = CMP_W'(length);
  assign in_pos_e  = CMP_W'(req.pos);
  assign req_pos_e = CMP_W'(req_pos);
  assign full      = (length == LEN_W'(DEPTH));
  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next    = state;
    length_next   = length;
    cur_next      = cur;
    res_data_next = res_data;
    res_ok_next   = res_ok;
    ram           = '0;
    res.valid     = 1'b0;
    res.data      = DATA_W'(res_data);
    res.ok        = res_ok;
    res.count     = CNT_W'(length);

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          res_ok_next   = 1'b0;
          res_data_next = '0;
          state_next    = ST_FINISH;
          case (req.kind)
            KIND_GET, KIND_SET, KIND_REMOVE: begin
              if (in_pos_e < len_e) begin
                // read issued now, word is back in RDUSE
                ram.raddr   = ADDR_W'(req.pos);
                res_ok_next = 1'b1;
                state_next  = ST_RDUSE;
              end
            end
            KIND_APPEND: begin
              if (!full) begin
                ram.we      = 1'b1;
                ram.waddr   = ADDR_W'(length);
                ram.wdata   = req.word;
                length_next = length + 1'b1;
                res_ok_next = 1'b1;
              end
            end
            KIND_INSERT: begin
              if (in_pos_e <= len_e && !full) begin
                res_ok_next = 1'b1;
                cur_next    = length;
                state_next  = (in_pos_e == len_e) ? ST_PUT : ST_SHIFT_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_RDUSE: begin
        res_data_next = ram_rdata;
        state_next    = ST_FINISH;
        case (req_kind)
          KIND_SET: begin
            ram.we    = 1'b1;
            ram.waddr = ADDR_W'(req_pos);
            ram.wdata = req_item;
          end
          KIND_REMOVE: begin
            cur_next = LEN_W'(req_pos);
            if (req_pos_e < len_e - 1'b1) begin
              state_next = ST_SHIFT_RD;
            end else begin
              length_next = length - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SHIFT_RD: begin
        // insert walks down from the tail, remove walks up from the hole
        ram.raddr  = (req_kind == KIND_INSERT) ? ADDR_W'(cur - 1'b1) : ADDR_W'(cur + 1'b1);
        state_next = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        ram.we    = 1'b1;
        ram.waddr = ADDR_W'(cur);
        ram.wdata = ram_rdata;
        if (req_kind == KIND_INSERT) begin
          cur_next   = cur - 1'b1;
          state_next = (CMP_W'(cur - 1'b1) == req_pos_e) ? ST_PUT : ST_SHIFT_RD;
        end else begin
          cur_next = cur + 1'b1;
          if (CMP_W'(cur + 1'b1) < len_e - 1'b1) begin
            state_next = ST_SHIFT_RD;
          end else begin
            length_next = length - 1'b1;
            state_next  = ST_FINISH;
          end
        end
      end

      ST_PUT: begin
        ram.we      = 1'b1;
        ram.waddr   = ADDR_W'(req_pos);
        ram.wdata   = req_item;
        length_next = length + 1'b1;
        state_next  = ST_FINISH;
      end

      ST_FINISH: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      length <= '0;
    end else begin
      state  <= state_next;
      length <= length_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    res_data <= res_data_next;
    res_ok   <= res_ok_next;
    if (accept) begin
      req_kind <= req.kind;
      req_pos  <= req.pos;
      req_item <= req.word;
    end
  end

  `ISL_ASSERT_IMPLIES(a_len_max, clk, rst, 1'b1, length <= LEN_W'(DEPTH))
  `ISL_ASSERT_IMPLIES(a_wr_in_list, clk, rst, ram.we, LEN_W'(ram.waddr) <= length)
  `ISL_ASSERT_NEXT(a_fail_direct, clk, rst, accept && !res_ok_next,
                   state == ST_FINISH && length == $past(length))

endmodule

FILE: rtl/indexed_shift_list_unit.sv
// Append and failed requests go from IDLE straight to FINISH; get, set and remove read
// in RDUSE; insert and remove add a SHIFT_RD/SHIFT_WR pair per moved entry, and insert
// writes the new item in PUT. One request at a time; a shift moves each entry through
// the RAM's read and write ports. The next beat is taken once the result enters the
// output register, even while that result still waits. Synchronous active-high reset
// empties the list; the word store itself is not cleared.
`include "indexed_shift_list_unit_macros.svh"

module indexed_shift_list_unit
  import isl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // index[4:0], item[36:5], zero fill
  input  logic [KIND_W-1:0]      s_tuser,  // kind[2:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // data[31:0], count[36:32], zero fill
  output logic                   m_tuser   // ok
);

  req_t                 req;
  ram_req_t             ram;
  logic [WORD_BITS-1:0] ram_rdata;
  res_t                 res;
  logic                 res_ready;
  logic [DATA_W-1:0]    out_data;
  logic [CNT_W-1:0]     out_count;
  logic                 out_ok;

  logic [ITEM_W-1:0] in_item;

  assign in_item  = s_tdata[IDX_W +: ITEM_W];
  assign req.kind = kind_t'(s_tuser);
  assign req.pos  = s_tdata[IDX_W-1:0];
  assign req.word = WORD_BITS'(in_item);

  isl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .ram       (ram),
    .ram_rdata (ram_rdata),
    .res       (res),
    .res_ready (res_ready)
  );

  isl_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_data  <= res.data;
      out_count <= res.count;
      out_ok    <= res.ok;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_count, out_data});
  assign m_tuser = out_ok;

  `ISL_ASSERT_IMPLIES(a_fail_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[DATA_W-1:0] == '0)
  `ISL_ASSERT_NEXT(a_no_drop, clk, rst, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

FILE: verif/tb_indexed_shift_list_unit.sv
module tb_indexed_shift_list_unit
  import isl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KIND_LAST     = (1 << KIND_W) - 1;
  localparam int IDX_LAST      = (1 << IDX_W) - 1;
  localparam int RAND_REQS     = 1150;
  localparam int MAX_GAP       = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [ITEM_W-1:0] word;
    int                gap;
    bit                drain;   // hold this beat until every result is back
  } list_req_t;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              ok;
    logic [CNT_W-1:0]  count;
  } list_resp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  indexed_shift_list_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  list_req_t  pending[$];
  list_resp_t awaited[$];

  logic [WORD_BITS-1:0] shadow_words[DEPTH];
  int     shadow_len = 0;
  int     gen_len = 0;
  int     mismatches = 0;
  longint cycles = 0;
  int     reqs_taken = 0;
  bit     req_taken = 1'b0;
  bit     resp_taken = 1'b0;
  bit     busy = 1'b0;
  int     gap_left = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  int     holds_done = 0;

  // list model: applies one request, returns the result beat it should produce
  function automatic list_resp_t apply_request(logic [KIND_W-1:0] kind,
                                               logic [IDX_W-1:0] idx,
                                               logic [ITEM_W-1:0] word);
    list_resp_t r;
    int p;
    r.data = '0;
    r.ok   = 1'b0;
    p      = idx;
    case (kind)
      KIND_GET: begin
        if (p < shadow_len) begin
          r.data = shadow_words[p];
          r.ok   = 1'b1;
        end
      end
      KIND_SET: begin
        if (p < shadow_len) begin
          r.data         = shadow_words[p];
          shadow_words[p] = word[WORD_BITS-1:0];
          r.ok           = 1'b1;
        end
      end
      KIND_APPEND: begin
        if (shadow_len < DEPTH) begin
          shadow_words[shadow_len] = word[WORD_BITS-1:0];
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      KIND_INSERT: begin
        if (p <= shadow_len && shadow_len < DEPTH) begin
          for (int i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = word[WORD_BITS-1:0];
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (p < shadow_len) begin
          r.data = shadow_words[p];
          for (int i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = shadow_len[CNT_W-1:0];
    return r;
  endfunction

  // gen_len only steers the index choice of later requests
  task automatic queue_request(logic [KIND_W-1:0] kind, int idx,
                               logic [ITEM_W-1:0] word, bit drain = 1'b0);
    list_req_t q;
    q.kind  = kind;
    q.idx   = idx[IDX_W-1:0];
    q.word  = word;
    q.drain = drain;
    q.gap   = ((pending.size() / 80) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
    pending.push_back(q);
    case (kind)
      KIND_APPEND: if (gen_len < DEPTH) gen_len++;
      KIND_INSERT: if (idx <= gen_len && gen_len < DEPTH) gen_len++;
      KIND_REMOVE: if (idx < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // sender
  always @(negedge clk) begin
    list_req_t cur;
    if (rst) begin
      s_tvalid <= 1'b0;
      busy     = 1'b0;
      gap_left = 0;
    end else begin
      if (req_taken) begin
        req_taken = 1'b0;
        busy      = 1'b0;
        if (pending.size() > 0) gap_left = pending[0].gap;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 && !(pending[0].drain && awaited.size() > 0)) begin
          cur = pending.pop_front();
          s_tdata <= IN_TDATA_W'({cur.word, cur.idx});
          s_tuser <= cur.kind;
          busy = 1'b1;
        end
      end
      s_tvalid <= busy;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
    end else begin
      if (resp_taken) begin
        resp_taken = 1'b0;
        stall_left = ((reqs_taken / 100) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
      end
      m_tready <= (stall_left == 0) && (hold_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && reqs_taken >= 300 + 500 * holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // monitor: checks result beats, predicts on accepted request beats
  always @(posedge clk) begin
    list_resp_t want;
    list_resp_t got;
    if (!rst) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, awaited.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        if (m_tvalid && m_tready) begin
          resp_taken = 1'b1;
          got.data   = m_tdata[DATA_W-1:0];
          got.count  = m_tdata[DATA_W +: CNT_W];
          got.ok     = m_tuser;
          if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("unexpected result beat: data %h ok %b count %0d",
                       got.data, got.ok, got.count);
          end else begin
            want = awaited.pop_front();
            if (got.data !== want.data || got.ok !== want.ok || got.count !== want.count) begin
              mismatches++;
              if (mismatches <= MAX_REPORTS)
                $display("result mismatch: expected data %h ok %b count %0d, got data %h ok %b count %0d",
                         want.data, want.ok, want.count, got.data, got.ok, got.count);
            end
          end
        end
        if (s_tvalid && s_tready) begin
          req_taken = 1'b1;
          reqs_taken++;
          awaited.push_back(apply_request(s_tuser, s_tdata[IDX_W-1:0],
                                          s_tdata[IDX_W +: ITEM_W]));
        end
      end
    end
  end

  initial begin
    int mode;
    int roll;
    int idx;
    logic [KIND_W-1:0] kind;
    logic [ITEM_W-1:0] word;

    // directed: empty list, ends of the list, bad indexes, unused kinds
    queue_request(KIND_GET, 0, '0);
    queue_request(KIND_REMOVE, 0, '0);
    queue_request(KIND_SET, 0, '1);
    queue_request(KIND_INSERT, 1, '1);
    queue_request(KIND_INSERT, 0, 32'hFFFF_FFFF);
    queue_request(KIND_APPEND, IDX_LAST, 32'h0000_0000);
    queue_request(KIND_INSERT, 2, 32'hAAAA_AAAA);
    queue_request(KIND_INSERT, 1, 32'h5555_5555);
    queue_request(KIND_GET, 3, '0);
    queue_request(KIND_GET, 4, '0);
    queue_request(KIND_SET, 0, 32'h1234_5678);
    queue_request(KIND_SET, 4, 32'h8765_4321);
    for (int k = KIND_REMOVE + 1; k <= KIND_LAST; k++) queue_request(KIND_W'(k), 0, '1);
    queue_request(KIND_REMOVE, 3, '0);
    queue_request(KIND_REMOVE, 0, '0);
    queue_request(KIND_GET, IDX_LAST, '0);
    queue_request(KIND_INSERT, DEPTH, '1);
    queue_request(KIND_REMOVE, DEPTH, '0);

    // random: phases that grow, shrink or churn the list
    mode = 0;
    for (int n = 0; n < RAND_REQS; n++) begin
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      word = $urandom;
      case ($urandom_range(0, 9))
        0: word = '0;
        1: word = '1;
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, IDX_LAST);
      else idx = $urandom_range(0, gen_len);
      if (roll < 3) begin
        kind = KIND_W'($urandom_range(KIND_REMOVE + 1, KIND_LAST));
      end else if (mode == 0) begin
        if (roll < 45)      kind = KIND_APPEND;
        else if (roll < 75) kind = KIND_INSERT;
        else if (roll < 85) kind = KIND_GET;
        else if (roll < 92) kind = KIND_SET;
        else                kind = KIND_REMOVE;
      end else if (mode == 1) begin
        if (roll < 50)      kind = KIND_REMOVE;
        else if (roll < 65) kind = KIND_GET;
        else if (roll < 80) kind = KIND_SET;
        else if (roll < 90) kind = KIND_APPEND;
        else                kind = KIND_INSERT;
      end else begin
        if (roll < 22)      kind = KIND_GET;
        else if (roll < 41) kind = KIND_SET;
        else if (roll < 60) kind = KIND_APPEND;
        else if (roll < 80) kind = KIND_INSERT;
        else                kind = KIND_REMOVE;
      end
      queue_request(kind, idx, word, n == 400 || n == 800);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending.size() > 0 || busy || awaited.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/isl_pkg.sv
rtl/isl_ram.sv
rtl/isl_ctrl.sv
rtl/indexed_shift_list_unit.sv
verif/tb_indexed_shift_list_unit.sv
